// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; imhd_datapath.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define IMHD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property failed");
// Checks that a condition never occurs outside reset.
`define IMHD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IMHD_ASSERT(lbl, clk, rstn, prop)
`define IMHD_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/imhd_pkg.sv =====
package imhd_pkg;

  localparam int KEY_BITS = 10;
  localparam int KEY_SPACE = 1024;
  localparam int CAPACITY_DEF = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IN_VALUE_BITS = 16;
  localparam int OCC_BITS = 11;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DEC    = 2'd1,
    MODE_POP    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic [KEY_BITS-1:0]      entry_key;
    logic [IN_VALUE_BITS-1:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]      out_key;
    logic [IN_VALUE_BITS-1:0] out_value;
    logic [2:0]               status;
    logic [OCC_BITS-1:0]      occupancy;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_INS_START,
    OP_DEC_START,
    OP_DEC_LOAD,
    OP_UP_RD,
    OP_UP_STEP,
    OP_PLACE,
    OP_POP_RD0,
    OP_POP_TAKE,
    OP_POP_LAST,
    OP_DN_RDL,
    OP_DN_RDR,
    OP_DN_STEP,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       present;
    logic       one_left;
    logic       at_root;
    logic       up_move;
    logic       dn_leaf;
    logic       dn_move;
    logic       out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/indexed_min_heap_decrement_top.sv =====
// Indexed binary min-heap of (key, value) entries with a decrement operation.
// Input channel: in_valid_i / in_stall_o carry an item with a mode (insert,
// decrement, pop), a 10-bit key and a value. Output channel: out_valid_o /
// out_stall_i carry one result item per input item: popped key and value,
// a status code and the occupancy after the item.
// An item is taken when valid is high and stall is low. The block works on
// one item at a time; a sift unit shared by insert, decrement and pop walks
// one heap level per step through a single-port-read heap memory.
// A rejected item or an unused mode goes from the lookup straight to the
// result; a pop that empties the heap first takes the root. Insert climbs
// one level per step (a parent read, then a compare and move); decrement
// first reads the key's entry and lowers its value by one (not below zero),
// then climbs the same way. Pop takes the root, moves the last entry to the
// root and descends one level per step (a leaf check, two child reads and a
// move). The next item is accepted the cycle after the result is queued.
// After reset the position table is cleared one key per cycle, all 1024
// keys, during which in_stall_o stays high.
// A finished result sits in an output register; if the receiver stalls, the
// block holds the result and accepts one more item, which waits for the
// register to drain before it is written out.
module indexed_min_heap_decrement_top import imhd_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cmd_t  cmd;
  stat_t stat;

  imhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  imhd_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_o),
    .out_valid_o (out_valid_o)
  );

endmodule

// ===== hw/rtl/imhd_ram.sv =====
module imhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== hw/rtl/imhd_datapath.sv =====
`include "assert_macros.svh"

module imhd_datapath import imhd_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_i,
  input  logic  out_stall_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output out_t  out_o,
  output logic  out_valid_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = KEY_BITS + VALUE_BITS;
  localparam int PW = 1 + IW;
  localparam int KAW = $clog2(KEY_SPACE);

  logic [CW-1:0]         cnt_q;
  logic [IW-1:0]         idx_q;
  logic [KEY_BITS-1:0]   ck_q, lk_q, key_q, okey_q;
  logic [VALUE_BITS-1:0] cv_q, lv_q, val_q;
  logic [1:0]            mode_q;
  logic [IN_VALUE_BITS-1:0] oval_q;
  logic [KAW-1:0]        clr_q;
  out_t                  out_q;
  logic                  out_valid_q;

  logic          h_we, h_re;
  logic [IW-1:0] h_wa, h_ra;
  logic [HW-1:0] h_wd, h_rd;
  logic          p_we, p_re;
  logic [KAW-1:0] p_wa, p_ra;
  logic [PW-1:0] p_wd, p_rd;

  imhd_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i(clk_i), .wr_en_i(h_we), .wr_addr_i(h_wa), .wr_data_i(h_wd),
    .rd_en_i(h_re), .rd_addr_i(h_ra), .rd_data_o(h_rd)
  );

  imhd_ram #(.WIDTH(PW), .DEPTH(KEY_SPACE)) u_pos_ram (
    .clk_i(clk_i), .wr_en_i(p_we), .wr_addr_i(p_wa), .wr_data_i(p_wd),
    .rd_en_i(p_re), .rd_addr_i(p_ra), .rd_data_o(p_rd)
  );

  logic [KEY_BITS-1:0]   hk;
  logic [VALUE_BITS-1:0] hv;
  logic [IW-1:0]         parent;
  logic [IW:0]           left_w;
  logic [IW+1:0]         right_w;
  logic                  has_right, right_win;
  logic [KEY_BITS-1:0]   c_key;
  logic [VALUE_BITS-1:0] c_val;
  logic [IW-1:0]         c_idx;
  logic [31:0]           in_val32, hv32, cnt32;

  assign hk       = h_rd[HW-1:VALUE_BITS];
  assign hv       = h_rd[VALUE_BITS-1:0];
  assign parent   = (idx_q - IW'(1)) >> 1;
  assign left_w   = {idx_q, 1'b1};
  assign right_w  = (IW+2)'(left_w) + (IW+2)'(1);
  assign has_right = right_w < (IW+2)'(cnt_q);
  // Right child wins only when strictly smaller than the left one.
  assign right_win = has_right && (hv < lv_q);
  assign c_key    = right_win ? hk : lk_q;
  assign c_val    = right_win ? hv : lv_q;
  assign c_idx    = right_win ? right_w[IW-1:0] : left_w[IW-1:0];
  assign in_val32 = 32'(in_i.entry_value);
  assign hv32     = 32'(hv);
  assign cnt32    = 32'(cnt_q);

  always_comb begin
    h_we = 1'b0; h_wa = idx_q; h_wd = {ck_q, cv_q};
    h_re = 1'b0; h_ra = '0;
    p_we = 1'b0; p_wa = ck_q;  p_wd = {1'b1, idx_q};
    p_re = 1'b0; p_ra = in_i.entry_key;
    case (cmd_i.op)
      OP_CLR: begin
        p_we = 1'b1; p_wa = clr_q; p_wd = '0;
      end
      OP_LOAD: begin
        p_re = 1'b1;
      end
      OP_DEC_START: begin
        h_re = 1'b1; h_ra = p_rd[IW-1:0];
      end
      OP_UP_RD: begin
        h_re = 1'b1; h_ra = parent;
      end
      OP_UP_STEP: begin
        h_we = 1'b1; p_we = 1'b1;
        if (hv > cv_q) begin
          h_wd = h_rd; p_wa = hk;
        end
      end
      OP_PLACE: begin
        h_we = 1'b1; p_we = 1'b1;
      end
      OP_POP_RD0: begin
        h_re = 1'b1;
      end
      OP_POP_TAKE: begin
        p_we = 1'b1; p_wa = hk; p_wd = '0;
        h_re = 1'b1; h_ra = IW'(cnt_q - CW'(1));
      end
      OP_DN_RDL: begin
        h_re = 1'b1; h_ra = left_w[IW-1:0];
      end
      OP_DN_RDR: begin
        h_re = 1'b1; h_ra = right_w[IW-1:0];
      end
      OP_DN_STEP: begin
        h_we = 1'b1; p_we = 1'b1;
        if (c_val < cv_q) begin
          h_wd = {c_key, c_val}; p_wa = c_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLR:       clr_q <= clr_q + KAW'(1);
        OP_INS_START: cnt_q <= cnt_q + CW'(1);
        OP_POP_TAKE:  cnt_q <= cnt_q - CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= in_i.mode;
        key_q  <= in_i.entry_key;
        val_q  <= in_val32[VALUE_BITS-1:0];
        okey_q <= '0;
        oval_q <= '0;
      end
      OP_INS_START: begin
        idx_q <= cnt_q[IW-1:0];
        ck_q  <= key_q;
        cv_q  <= val_q;
      end
      OP_DEC_START: idx_q <= p_rd[IW-1:0];
      OP_DEC_LOAD: begin
        ck_q <= key_q;
        cv_q <= (hv == '0) ? hv : hv - VALUE_BITS'(1);
      end
      OP_UP_STEP: begin
        if (hv > cv_q) begin
          idx_q <= parent;
        end
      end
      OP_POP_TAKE: begin
        okey_q <= hk;
        oval_q <= hv32[IN_VALUE_BITS-1:0];
      end
      OP_POP_LAST: begin
        ck_q  <= hk;
        cv_q  <= hv;
        idx_q <= '0;
      end
      OP_DN_RDR: begin
        lk_q <= hk;
        lv_q <= hv;
      end
      OP_DN_STEP: begin
        if (c_val < cv_q) begin
          idx_q <= c_idx;
        end
      end
      OP_RESULT: begin
        out_q.out_key   <= okey_q;
        out_q.out_value <= oval_q;
        out_q.status    <= cmd_i.status;
        out_q.occupancy <= cnt32[OCC_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.clr_last = &clr_q;
    stat_o.mode     = mode_q;
    stat_o.full     = cnt_q >= CW'(CAPACITY);
    stat_o.empty    = cnt_q == '0;
    stat_o.present  = p_rd[PW-1];
    stat_o.one_left = cnt_q == CW'(1);
    stat_o.at_root  = idx_q == '0;
    stat_o.up_move  = hv > cv_q;
    stat_o.dn_leaf  = (CW+1)'(left_w) >= (CW+1)'(cnt_q);
    stat_o.dn_move  = c_val < cv_q;
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  `IMHD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(CAPACITY))
  `IMHD_ASSERT(a_no_overwrite, clk_i, rst_ni,
               cmd_i.op == OP_RESULT |-> !(out_valid_q && out_stall_i))
  `IMHD_ASSERT(a_clear_empty, clk_i, rst_ni, cmd_i.op == OP_CLR |-> cnt_q == '0)
  `IMHD_NEVER(a_ins_full, clk_i, rst_ni,
              cmd_i.op == OP_INS_START && cnt_q >= CW'(CAPACITY))

endmodule

// ===== hw/rtl/imhd_ctrl.sv =====
module imhd_ctrl import imhd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_stall_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_DEC_LOAD, S_UP_CHK, S_UP_STEP,
    S_POP_TAKE, S_POP_LAST, S_DN_CHK, S_DN_RDR, S_DN_STEP, S_RESULT
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    cmd_o.op     = OP_NONE;
    cmd_o.status = status_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          status_d = ST_OK;
          state_d  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_RESULT;
        case (stat_i.mode)
          MODE_INSERT: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else if (stat_i.present) begin
              status_d = ST_PRESENT;
            end else begin
              cmd_o.op = OP_INS_START;
              state_d  = S_UP_CHK;
            end
          end
          MODE_DEC: begin
            if (!stat_i.present) begin
              status_d = ST_ABSENT;
            end else begin
              cmd_o.op = OP_DEC_START;
              state_d  = S_DEC_LOAD;
            end
          end
          MODE_POP: begin
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.op = OP_POP_RD0;
              state_d  = S_POP_TAKE;
            end
          end
          default: begin
          end
        endcase
      end
      S_DEC_LOAD: begin
        cmd_o.op = OP_DEC_LOAD;
        state_d  = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (stat_i.at_root) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UP_STEP;
        end
      end
      S_UP_STEP: begin
        cmd_o.op = OP_UP_STEP;
        state_d  = stat_i.up_move ? S_UP_CHK : S_RESULT;
      end
      S_POP_TAKE: begin
        cmd_o.op = OP_POP_TAKE;
        state_d  = stat_i.one_left ? S_RESULT : S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd_o.op = OP_POP_LAST;
        state_d  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat_i.dn_leaf) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = OP_DN_RDL;
          state_d  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd_o.op = OP_DN_RDR;
        state_d  = S_DN_STEP;
      end
      S_DN_STEP: begin
        cmd_o.op = OP_DN_STEP;
        state_d  = stat_i.dn_move ? S_DN_CHK : S_RESULT;
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import imhd_pkg::*;

  localparam int HEAP_SIZE = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  indexed_min_heap_decrement_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the heap, kept in the same slot order as the block so
  // that tie-breaking between equal values follows the same path.
  logic [KEY_BITS-1:0] shadow_key[HEAP_SIZE];
  logic [15:0] shadow_val[HEAP_SIZE];
  int unsigned slot_of_key[KEY_SPACE];
  bit key_live[KEY_SPACE];
  int unsigned heap_count;

  in_t pending_items[$];
  out_t expected_results[$];
  int mismatches = 0;
  bit stim_done = 0;
  int idle_cycles = 0;
  bit in_taken = 0;
  bit out_taken = 0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_BITS-1:0] ka;
    logic [15:0] va;
    ka = shadow_key[a];
    va = shadow_val[a];
    shadow_key[a] = shadow_key[b];
    shadow_val[a] = shadow_val[b];
    shadow_key[b] = ka;
    shadow_val[b] = va;
    slot_of_key[shadow_key[a]] = a;
    slot_of_key[shadow_key[b]] = b;
  endfunction

  function automatic void climb(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (shadow_val[p] > shadow_val[i]) begin
        swap_slots(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void descend();
    int unsigned i, l, r, c;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      if (l >= heap_count) break;
      c = (r < heap_count && shadow_val[r] < shadow_val[l]) ? r : l;
      if (shadow_val[c] < shadow_val[i]) begin
        swap_slots(i, c);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  // Applies one item to the shadow heap and returns the result it should give.
  function automatic out_t apply_heap_item(in_t it);
    out_t res;
    int unsigned s;
    res = '0;
    res.status = ST_OK;
    case (it.mode)
      MODE_INSERT: begin
        if (heap_count >= HEAP_SIZE) begin
          res.status = ST_FULL;
        end else if (key_live[it.entry_key]) begin
          res.status = ST_PRESENT;
        end else begin
          s = heap_count;
          shadow_key[s] = it.entry_key;
          shadow_val[s] = it.entry_value;
          slot_of_key[it.entry_key] = s;
          key_live[it.entry_key] = 1;
          heap_count++;
          climb(s);
        end
      end
      MODE_DEC: begin
        if (!key_live[it.entry_key]) begin
          res.status = ST_ABSENT;
        end else begin
          s = slot_of_key[it.entry_key];
          if (shadow_val[s] > 0) shadow_val[s] = shadow_val[s] - 16'd1;
          climb(s);
        end
      end
      MODE_POP: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_key = shadow_key[0];
          res.out_value = shadow_val[0];
          key_live[shadow_key[0]] = 0;
          heap_count--;
          if (heap_count > 0) begin
            shadow_key[0] = shadow_key[heap_count];
            shadow_val[0] = shadow_val[heap_count];
            slot_of_key[shadow_key[0]] = 0;
            descend();
          end
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_BITS'(heap_count);
    return res;
  endfunction

  function automatic in_t make_item(logic [1:0] m, int unsigned k, int unsigned v);
    in_t it;
    it.mode = m;
    it.entry_key = KEY_BITS'(k);
    it.entry_value = IN_VALUE_BITS'(v);
    return it;
  endfunction

  // Stimulus: a directed opening, then a random part. Key choice favors
  // a small pool for hits on present keys, and the heap is filled completely
  // once so that full inserts and deep sifts both occur.
  initial begin
    int unsigned r;
    int unsigned k;
    pending_items.push_back(make_item(MODE_POP, 0, 0));
    pending_items.push_back(make_item(MODE_DEC, 5, 0));
    pending_items.push_back(make_item(MODE_INSERT, 1023, 16'hFFFF));
    pending_items.push_back(make_item(MODE_INSERT, 0, 0));
    pending_items.push_back(make_item(MODE_INSERT, 0, 7));
    pending_items.push_back(make_item(MODE_INSERT, 512, 0));
    pending_items.push_back(make_item(MODE_INSERT, 341, 16'h5555));
    pending_items.push_back(make_item(MODE_INSERT, 682, 16'hAAAA));
    pending_items.push_back(make_item(MODE_DEC, 0, 0));
    pending_items.push_back(make_item(MODE_DEC, 1023, 0));
    pending_items.push_back(make_item(MODE_DEC, 682, 16'hFFFF));
    pending_items.push_back(make_item(MODE_UNUSED, 1023, 16'hFFFF));
    for (int i = 0; i < 7; i++) pending_items.push_back(make_item(MODE_POP, i, 0));
    // Fill the heap to capacity with all keys, values descending to climb deep.
    for (int i = 0; i < HEAP_SIZE; i++)
      pending_items.push_back(make_item(MODE_INSERT, i, (HEAP_SIZE - i) * 37));
    pending_items.push_back(make_item(MODE_INSERT, 3, 1));
    for (int i = 0; i < 40; i++)
      pending_items.push_back(make_item(MODE_DEC, $urandom_range(0, 1023), 0));
    for (int i = 0; i < 150; i++)
      pending_items.push_back(make_item(MODE_POP, 0, 0));
    for (int i = 0; i < 316; i++) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
      if (r < 40)
        pending_items.push_back(make_item(MODE_INSERT, k,
          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535)));
      else if (r < 65) pending_items.push_back(make_item(MODE_DEC, k, $urandom_range(0, 65535)));
      else if (r < 98) pending_items.push_back(make_item(MODE_POP, k, $urandom_range(0, 65535)));
      else pending_items.push_back(make_item(MODE_UNUSED, k, $urandom_range(0, 65535)));
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: holds each item until accepted, then waits a random gap.
  // The receiver waits a random number of cycles after each taken result.
  int send_gap = 0;
  int out_wait = 0;
  always @(negedge clk_i) begin
    bit taken;
    bit drained;
    if (rst_ni) begin
      taken = in_taken;
      in_taken = 0;
      drained = out_taken;
      out_taken = 0;
      if (taken) begin
        // The item went in at the last rising edge.
        void'(pending_items.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (in_valid_i && !taken) begin
        // Payload stays put while stalled.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_i <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
        stim_done = 1;
      end
      if (drained) out_wait = $urandom_range(0, 15);
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts at input acceptance, checks at output acceptance.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_heap_item(in_i));
        in_taken = 1;
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        out_taken = 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result item %h", out_o);
        end else begin
          want = expected_results.pop_front();
          if (out_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected key %0d value %0d status %0d occ %0d,",
                        " got key %0d value %0d status %0d occ %0d"},
                       want.out_key, want.out_value, want.status, want.occupancy,
                       out_o.out_key, out_o.out_value, out_o.status, out_o.occupancy);
          end
        end
      end
    end
  end

  // End of run: drain, allow a latency tail, then report.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (stim_done && expected_results.size() == 0 && !in_valid_i) break;
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/imhd_pkg.sv
hw/rtl/imhd_ram.sv
hw/rtl/imhd_datapath.sv
hw/rtl/imhd_ctrl.sv
hw/rtl/indexed_min_heap_decrement_top.sv
verif/tb_top.sv
